/* hw/rtl/csr_row_block_partitioner_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the CSR row-block partitioner
// Concurrent checks on the clk / rst_n domain; empty for synthesis.
// ---------------------------------------------------------------------------
`ifndef CSR_ROW_BLOCK_PARTITIONER_MACROS_SVH
`define CSR_ROW_BLOCK_PARTITIONER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define CRBP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define CRBP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define CRBP_ASSERT_NOW(label, ante, cons, msg)
`define CRBP_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

/* hw/rtl/crbp_pkg.sv */
// ---------------------------------------------------------------------------
// crbp_pkg
// Widths, reset values and shared types of the CSR row-block partitioner.
// ---------------------------------------------------------------------------
package crbp_pkg;

    // Field widths
    localparam int NNZ_W    = 16;             // row nonzero count and budget
    localparam int ROW_W    = 32;             // row index and block number
    localparam int BNNZ_W   = NNZ_W + 1;      // block nonzero count
    localparam int RINC_W   = NNZ_W + 2;      // rows in block plus one

    // Budget after reset
    localparam logic [NNZ_W-1:0] BUDGET_RESET = 16'd1024;

    // Result queue geometry
    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCNT_W   = $clog2(QDEPTH + 1);

    // Stream packing
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_FIELD_W = ROW_W + BNNZ_W + ROW_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

    // One closed block
    typedef struct packed {
        logic [ROW_W-1:0]  end_row;
        logic [BNNZ_W-1:0] nnz;
        logic [ROW_W-1:0]  number;
        logic              last;
        logic              done;
    } crbp_result_t;

    // Results caused by one row: zero, one or two blocks
    typedef struct packed {
        logic [1:0]   count;
        crbp_result_t res_a;
        crbp_result_t res_b;
    } crbp_emit_t;

endpackage

/* hw/rtl/csr_row_block_partitioner.sv */
// ---------------------------------------------------------------------------
// csr_row_block_partitioner
// Groups CSR rows into blocks against a nonzero budget and reports each block.
// ---------------------------------------------------------------------------
// Usage:
//   s_* carries one request per row, in row order: s_tdata[15:0] is the row's
//   nonzero count, s_tlast marks the matrix's last row.
//   m_* carries one request per closed block: end row, nonzero count and
//   running block number in m_tdata; m_tlast flags the last block caused by a
//   row, m_tuser flags the block that closes the matrix.
//   cfg_wr_en / cfg_wr_data set the nonzero budget (1024 after reset); write
//   it only between matrices or while no row is in flight.
// Timing:
//   A row's blocks are decided in the cycle it is accepted, registered into the
//   result queue and then shown on m_*. One row is taken per cycle while
//   s_tready is high; a row can close two blocks, and the 4-entry result queue
//   drains one block per cycle while m_tready is high, one block per transfer.
// Reset and stall:
//   Reset empties the queue and clears all block state. When m_tready is low
//   the queue fills; s_tready drops while fewer than two entries are free.
// ---------------------------------------------------------------------------
module csr_row_block_partitioner
    import crbp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Configuration
    input  logic                   cfg_wr_en,
    input  logic [NNZ_W-1:0]       cfg_wr_data,
    // Row input
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,    // [15:0] row_nnz
    input  logic                   s_tlast,    // final_row
    // Block output
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,    // [31:0] block_end_row,
                                               // [48:32] block_nnz,
                                               // [80:49] block_number, rest zero
    output logic                   m_tlast,    // run_last
    output logic                   m_tuser     // matrix_done
);

    logic         accept;
    crbp_emit_t   emit;
    crbp_result_t out_res;

    // Take a row request when the queue has room for two blocks
    assign accept = s_tvalid && s_tready;

    crbp_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .accept      (accept),
        .row_nnz     (s_tdata[NNZ_W-1:0]),
        .final_row   (s_tlast),
        .emit        (emit)
    );

    crbp_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .emit      (emit),
        .space_ok  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    // Pack the block request
    assign m_tdata = {{OUT_PAD_W{1'b0}}, out_res.number, out_res.nnz, out_res.end_row};
    assign m_tlast = out_res.last;
    assign m_tuser = out_res.done;

endmodule

/* hw/rtl/crbp_core.sv */
// ---------------------------------------------------------------------------
// crbp_core
// Holds the open block and decides, per row, which blocks close.
// ---------------------------------------------------------------------------
`include "csr_row_block_partitioner_macros.svh"

module crbp_core
    import crbp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [NNZ_W-1:0]  cfg_wr_data,
    input  logic              accept,
    input  logic [NNZ_W-1:0]  row_nnz,
    input  logic              final_row,
    output crbp_emit_t        emit
);

    logic [NNZ_W-1:0]  budget_reg;
    logic [NNZ_W-1:0]  pending_reg, pending_next;
    logic [BNNZ_W-1:0] rows_reg, rows_next;
    logic [ROW_W-1:0]  row_index_reg, row_index_next;
    logic [ROW_W-1:0]  blocks_reg, blocks_next;

    logic [BNNZ_W-1:0] sum_full;
    logic [BNNZ_W-1:0] sum_eff;
    logic [RINC_W-1:0] rows_inc;
    logic              pre_close;
    logic              close;
    logic [ROW_W-1:0]  cur_row;
    logic [ROW_W-1:0]  num_a;
    logic [ROW_W-1:0]  num_b;

    // Budget register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            budget_reg <= BUDGET_RESET;
        end
        else if (cfg_wr_en)
        begin
            budget_reg <= cfg_wr_data;
        end
    end

    // Close decision: early close before an overflowing row, then normal close
    always_comb
    begin
        sum_full  = {1'b0, pending_reg} + {1'b0, row_nnz};
        pre_close = (sum_full > {1'b0, budget_reg}) && (rows_reg != '0);
        sum_eff   = pre_close ? {1'b0, row_nnz} : sum_full;
        rows_inc  = pre_close ? RINC_W'(1) : ({1'b0, rows_reg} + RINC_W'(1));
        close     = (sum_eff >= {1'b0, budget_reg})
                 || (rows_inc > {2'b0, budget_reg})
                 || final_row;
        cur_row   = row_index_reg + ROW_W'(1);
        num_a     = blocks_reg + ROW_W'(1);
        num_b     = blocks_reg + ROW_W'(2);
    end

    // Build the results of this row
    always_comb
    begin
        emit = '0;
        unique case ({pre_close, close})
            2'b11:
            begin
                emit.count = 2'd2;
                emit.res_a = '{end_row: row_index_reg, nnz: {1'b0, pending_reg},
                               number: num_a, last: 1'b0, done: 1'b0};
                emit.res_b = '{end_row: cur_row, nnz: sum_eff,
                               number: num_b, last: 1'b1, done: final_row};
            end
            2'b10:
            begin
                emit.count = 2'd1;
                emit.res_a = '{end_row: row_index_reg, nnz: {1'b0, pending_reg},
                               number: num_a, last: 1'b1, done: 1'b0};
            end
            2'b01:
            begin
                emit.count = 2'd1;
                emit.res_a = '{end_row: cur_row, nnz: sum_eff,
                               number: num_a, last: 1'b1, done: final_row};
            end
            default:
            begin
                emit.count = 2'd0;
            end
        endcase
    end

    // Next block state; the last row returns everything to zero
    always_comb
    begin
        pending_next   = pending_reg;
        rows_next      = rows_reg;
        row_index_next = row_index_reg;
        blocks_next    = blocks_reg;
        if (accept)
        begin
            if (final_row)
            begin
                pending_next   = '0;
                rows_next      = '0;
                row_index_next = '0;
                blocks_next    = '0;
            end
            else
            begin
                row_index_next = cur_row;
                if (pre_close && close)
                begin
                    blocks_next = num_b;
                end
                else if (pre_close || close)
                begin
                    blocks_next = num_a;
                end
                if (close)
                begin
                    pending_next = '0;
                    rows_next    = '0;
                end
                else
                begin
                    pending_next = sum_eff[NNZ_W-1:0];
                    rows_next    = rows_inc[BNNZ_W-1:0];
                end
            end
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= '0;
            rows_reg      <= '0;
            row_index_reg <= '0;
            blocks_reg    <= '0;
        end
        else
        begin
            pending_reg   <= pending_next;
            rows_reg      <= rows_next;
            row_index_reg <= row_index_next;
            blocks_reg    <= blocks_next;
        end
    end

    // Checks
    `CRBP_ASSERT_NEXT(a_final_clears, accept && final_row, (row_index_reg == '0) && (blocks_reg == '0) && (pending_reg == '0) && (rows_reg == '0), "last row left block state behind")
    `CRBP_ASSERT_NOW(a_pair_numbers, accept && (emit.count == 2'd2), emit.res_b.number == (emit.res_a.number + ROW_W'(1)), "paired blocks not numbered in sequence")
    `CRBP_ASSERT_NOW(a_final_closes, accept && final_row, (emit.count != 2'd0) && (emit.count == 2'd2 ? emit.res_b.done : emit.res_a.done), "last row did not close the final block")

endmodule

/* hw/rtl/crbp_outq.sv */
// ---------------------------------------------------------------------------
// crbp_outq
// Small result queue: takes up to two results a cycle, hands out one.
// ---------------------------------------------------------------------------
`include "csr_row_block_partitioner_macros.svh"

module crbp_outq
    import crbp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  crbp_emit_t    emit,
    output logic          space_ok,
    output logic          out_valid,
    input  logic          out_ready,
    output crbp_result_t  out_res
);

    crbp_result_t         entry_reg [QDEPTH];
    logic [QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]    cnt_reg, cnt_next;
    logic [1:0]           push_cnt;
    logic                 pop;

    // Handshake status
    assign space_ok  = (cnt_reg <= QCNT_W'(QDEPTH - 2));
    assign out_valid = (cnt_reg != '0);
    assign out_res   = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    assign push_cnt  = push ? emit.count : 2'd0;

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(push_cnt);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
        cnt_next    = cnt_reg + QCNT_W'(push_cnt) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store results in arrival order
    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= emit.res_a;
        end
        if (push_cnt == 2'd2)
        begin
            entry_reg[wr_ptr_reg + QPTR_W'(1)] <= emit.res_b;
        end
    end

    // Checks
    `CRBP_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_reg <= QCNT_W'(QDEPTH), "result queue count out of range")
    `CRBP_ASSERT_NOW(a_push_fits, push_cnt == 2'd2, cnt_reg <= QCNT_W'(QDEPTH - 2), "pair pushed without room")
    `CRBP_ASSERT_NOW(a_push_count, push, emit.count != 2'd3, "row produced more than two blocks")

endmodule

/* test/csr_row_block_partitioner_tb.sv */
// ---------------------------------------------------------------------------
// csr_row_block_partitioner_tb
// Streams CSR row counts into the partitioner under several nonzero budgets
// and idle patterns, predicts every closed block in a block ledger and checks
// each block request field by field as it leaves the block.
// ---------------------------------------------------------------------------
package crbp_tb_pkg;

    import crbp_pkg::*;

    class block_ledger;

        logic [NNZ_W-1:0]  budget;
        logic [NNZ_W-1:0]  open_nnz;
        logic [BNNZ_W-1:0] open_rows;
        logic [ROW_W-1:0]  rows_taken;
        logic [ROW_W-1:0]  blocks_closed;
        crbp_result_t      blocks_due[$];
        int                errors;
        int                rows_seen;
        int                blocks_matched;
        int                matrices;

        function new();
            budget         = BUDGET_RESET;
            open_nnz       = '0;
            open_rows      = '0;
            rows_taken     = '0;
            blocks_closed  = '0;
            errors         = 0;
            rows_seen      = 0;
            blocks_matched = 0;
            matrices       = 0;
        endfunction

        // Close the open block and empty it
        function crbp_result_t close_block(logic [ROW_W-1:0] end_row,
                                           logic [BNNZ_W-1:0] nnz);
            crbp_result_t blk;
            blocks_closed = blocks_closed + 1'b1;
            blk.end_row   = end_row;
            blk.nnz       = nnz;
            blk.number    = blocks_closed;
            blk.last      = 1'b0;
            blk.done      = 1'b0;
            open_nnz      = '0;
            open_rows     = '0;
            return blk;
        endfunction

        // Advance the partition by one accepted row and queue its blocks
        function void take_row(logic [NNZ_W-1:0] nnz, logic fin);
            crbp_result_t      blk [2];
            logic [ROW_W-1:0]  this_end;
            logic [BNNZ_W-1:0] sum;
            int                n;
            n        = 0;
            this_end = rows_taken + 1'b1;
            sum      = {1'b0, open_nnz} + nnz;
            rows_seen++;
            // overflow of a block holding earlier rows: close before this row
            if (sum > budget && open_rows != 0)
            begin
                blk[n] = close_block(rows_taken, {1'b0, open_nnz});
                n++;
                sum = {1'b0, nnz};
            end
            // close at this row on budget reached, row span exceeded or last row
            if (sum >= budget || int'(open_rows) + 1 > int'(budget) || fin)
            begin
                blk[n] = close_block(this_end, sum);
                n++;
            end
            else
            begin
                open_nnz  = sum[NNZ_W-1:0];
                open_rows = open_rows + 1'b1;
            end
            rows_taken = this_end;
            if (n > 0)
            begin
                blk[n-1].last = 1'b1;
                blk[n-1].done = fin;
            end
            for (int i = 0; i < n; i++)
                blocks_due.insert(blocks_due.size(), blk[i]);
            // last row: start the next matrix from scratch
            if (fin)
            begin
                open_nnz      = '0;
                open_rows     = '0;
                rows_taken    = '0;
                blocks_closed = '0;
                matrices++;
            end
        endfunction

        // Compare one block request with the oldest predicted block
        function void match_block(crbp_result_t got);
            crbp_result_t want;
            if (blocks_due.size() == 0)
            begin
                $error("unexpected block: end row %0d, nnz %0d, number %0d",
                       got.end_row, got.nnz, got.number);
                errors++;
                return;
            end
            want = blocks_due.pop_front();
            blocks_matched++;
            if (got.end_row !== want.end_row)
            begin
                $error("block_end_row: expected %0d, got %0d", want.end_row, got.end_row);
                errors++;
            end
            if (got.nnz !== want.nnz)
            begin
                $error("block_nnz: expected %0d, got %0d", want.nnz, got.nnz);
                errors++;
            end
            if (got.number !== want.number)
            begin
                $error("block_number: expected %0d, got %0d", want.number, got.number);
                errors++;
            end
            if (got.last !== want.last)
            begin
                $error("run_last: expected %0b, got %0b", want.last, got.last);
                errors++;
            end
            if (got.done !== want.done)
            begin
                $error("matrix_done: expected %0b, got %0b", want.done, got.done);
                errors++;
            end
        endfunction

    endclass

endpackage

module csr_row_block_partitioner_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import crbp_pkg::*;
    import crbp_tb_pkg::*;

    localparam int QUIET_LIMIT   = 5000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ROWS    = 250;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    logic                   clk         = 1'b0;
    logic                   rst_n       = 1'b0;
    logic                   cfg_wr_en   = 1'b0;
    logic [NNZ_W-1:0]       cfg_wr_data = '0;
    logic                   s_tvalid    = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata     = '0;   // [15:0] row_nnz
    logic                   s_tlast     = 1'b0; // final_row
    logic                   m_tvalid;
    logic                   m_tready    = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;            // [31:0] block_end_row, [48:32] block_nnz,
                                                // [80:49] block_number, rest zero
    logic                   m_tlast;            // run_last
    logic                   m_tuser;            // matrix_done

    idle_mode_t  idle_mode    = IDLE_NONE;
    int          quiet_cycles = 0;
    int          budgets_used = 1;
    block_ledger ledger       = new();

    csr_row_block_partitioner DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

    // 12 ns clock
    always
    begin
        #6;
        clk = 1'b1;
        #6;
        clk = 1'b0;
    end

    function automatic logic sender_idles();
        if (idle_mode == IDLE_SENDER)
            return $urandom_range(99) < 80;
        if (idle_mode == IDLE_BOTH)
            return $urandom_range(99) < 24;
        return 1'b0;
    endfunction

    function automatic logic receiver_stalls();
        if (idle_mode == IDLE_RECEIVER)
            return $urandom_range(99) < 80;
        if (idle_mode == IDLE_BOTH)
            return $urandom_range(99) < 24;
        return 1'b0;
    endfunction

    // Offer one row request, hold it until taken, then note it in the ledger
    task automatic send_row(input logic [NNZ_W-1:0] nnz, input logic fin);
        if (sender_idles())
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while (sender_idles());
        end
        s_tvalid <= 1'b1;
        s_tdata  <= nnz;
        s_tlast  <= fin;
        do
            @(posedge clk);
        while (!s_tready);
        ledger.take_row(nnz, fin);
    endtask

    // Drop valid, drain every predicted block, then let the pipeline empty
    task automatic settle();
        s_tvalid <= 1'b0;
        while (ledger.blocks_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_budget(input logic [NNZ_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        ledger.budget = value;
        budgets_used++;
        cfg_wr_en <= 1'b0;
    endtask

    // Row counts aimed at the budget edges: exact fill, overflow, empty rows
    function automatic logic [NNZ_W-1:0] next_row_nnz();
        int b;
        int fill;
        b    = int'(ledger.budget);
        fill = b - int'(ledger.open_nnz);
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return NNZ_W'($urandom_range(65535));
            3:       return NNZ_W'(b);
            4:       return NNZ_W'(fill < 0 ? 0 : fill);
            5:       return NNZ_W'(b >= 65535 ? 65535 : b + 1);
            6:       return NNZ_W'($urandom_range(b));
            default: return NNZ_W'($urandom_range(b / 4 + 1));
        endcase
    endfunction

    function automatic logic [NNZ_W-1:0] phase_budget(input int ph);
        case (ph)
            0:       return NNZ_W'($urandom_range(8, 2));
            1:       return '1;
            2:       return NNZ_W'($urandom_range(300, 9));
            3:       return NNZ_W'(1);
            4:       return NNZ_W'($urandom_range(65535, 1));
            5:       return NNZ_W'($urandom_range(4000, 300));
            6:       return NNZ_W'($urandom_range(8, 2));
            default: return NNZ_W'($urandom_range(65535, 1000));
        endcase
    endfunction

    // Take block requests and check them; stall per the idle mode
    always @(posedge clk)
    begin : block_sink
        crbp_result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.end_row = m_tdata[ROW_W-1:0];
            got.nnz     = m_tdata[ROW_W+BNNZ_W-1:ROW_W];
            got.number  = m_tdata[OUT_FIELD_W-1:ROW_W+BNNZ_W];
            got.last    = m_tlast;
            got.done    = m_tuser;
            ledger.match_block(got);
        end
        m_tready <= !receiver_stalls();
    end

    // Abort when no request moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || cfg_wr_en || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout: no request moved for %0d cycles", QUIET_LIMIT);
            $display("csr_row_block_partitioner test failed");
            $finish;
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Budget after reset: empty row, exact fill, overflow with earlier rows,
        // overflow giving two blocks, lone overflowing row, last row
        send_row(16'd0, 1'b0);
        send_row(16'd1024, 1'b0);
        send_row(16'd500, 1'b0);
        send_row(16'd600, 1'b0);
        send_row(16'hFFFF, 1'b0);
        send_row(16'hFFFF, 1'b0);
        send_row(16'd10, 1'b1);
        send_row(16'd0, 1'b1);
        settle();

        // Budget of one: row span limit and oversized rows
        write_budget(16'd1);
        send_row(16'd0, 1'b0);
        send_row(16'd0, 1'b0);
        send_row(16'd1, 1'b0);
        send_row(16'hFFFF, 1'b0);
        send_row(16'hFFFF, 1'b1);
        settle();

        // Largest budget: exact fill and two blocks on the last row
        write_budget(16'hFFFF);
        send_row(16'hFFFF, 1'b0);
        send_row(16'hFFFE, 1'b0);
        send_row(16'd1, 1'b0);
        send_row(16'hFFFE, 1'b0);
        send_row(16'd2, 1'b0);
        send_row(16'hFFFF, 1'b1);
        settle();

        // Zero budget: every row closes its own block
        write_budget(16'd0);
        send_row(16'd0, 1'b0);
        send_row(16'd5, 1'b0);
        send_row(16'd7, 1'b1);
        settle();

        // Random matrices under each budget and idle pattern
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            write_budget(phase_budget(ph));
            idle_mode = idle_mode_t'(ph % 4);
            repeat (PHASE_ROWS)
                send_row(next_row_nnz(), $urandom_range(15) == 0);
            settle();
        end
        repeat (8) @(posedge clk);

        $display("covered %0d rows in %0d finished matrices under %0d budget settings",
                 ledger.rows_seen, ledger.matrices, budgets_used);
        $display("checked %0d blocks, %0d mismatches", ledger.blocks_matched, ledger.errors);
        if (ledger.errors == 0 && ledger.blocks_due.size() == 0)
            $display("csr_row_block_partitioner test passed");
        else
            $display("csr_row_block_partitioner test failed");
        $finish;
    end

endmodule
